>>> sv/evlcl_pkg.sv
`timescale 1ns / 1ps

package evlcl_pkg;

    typedef logic [2:0]  t_event_code;
    typedef logic [7:0]  t_credit;
    typedef logic [15:0] t_period;

    localparam logic REQ_EVENT = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam t_event_code EV_NONE     = 3'd0;
    localparam t_event_code EV_RATE_OFF = 3'd1;
    localparam t_event_code EV_RATE_ON  = 3'd2;
    localparam t_event_code EV_STARTED  = 3'd3;
    localparam t_event_code EV_STOPPED  = 3'd4;

    localparam logic CFG_CREDIT_MAX    = 1'b0;
    localparam logic CFG_REFILL_PERIOD = 1'b1;

    localparam t_credit CREDIT_MAX_RESET    = 8'd128;
    localparam t_period REFILL_PERIOD_RESET = 16'd300;

    typedef struct packed {
        logic    log_now;
        t_credit credits_left;
    } t_result;

endpackage

>>> sv/event_log_credit_limiter_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_stall    i_req_type, i_event_code
// result    out        o_valid / i_stall    o_log_now, o_credits_left
// config    in         i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// One request per cycle while o_stall is low; its result is registered.
// The decision and state update happen in the accept cycle, ahead of the
// result register; a one-entry skid register takes a result while the output
// is stalled, and o_stall rises only when that skid entry is full.
// Synchronous active-low reset restores credits, timer and registers.

module event_log_credit_limiter_top
    import evlcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [2:0]  i_event_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_log_now,
    output logic [7:0]  o_credits_left,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    t_credit     r_credit_max;
    t_period     r_refill_period;
    t_credit     r_credit_count, n_credit_count;
    t_event_code r_last_event, n_last_event;
    t_period     r_countdown, n_countdown;

    t_result     r_out, r_skid, n_result;
    logic        r_out_valid, r_skid_valid;

    logic        w_accept;
    logic        w_take;
    logic        w_costs;

    assign o_stall  = r_skid_valid;
    assign w_accept = i_valid && !r_skid_valid;
    assign w_take   = r_out_valid && !i_stall;

    always_comb begin
        case (i_event_code) inside
            EV_STARTED, EV_STOPPED: w_costs = 1'b1;
            EV_RATE_OFF, EV_RATE_ON: w_costs = (i_event_code != r_last_event);
            default: w_costs = 1'b0;
        endcase
    end

    always_comb begin
        n_credit_count   = r_credit_count;
        n_last_event     = r_last_event;
        n_countdown      = r_countdown;
        n_result.log_now = 1'b0;
        if (i_req_type == REQ_EVENT) begin
            // with no credits the event is dropped and not remembered
            if (r_credit_count != '0) begin
                if (w_costs) begin
                    n_credit_count   = r_credit_count - 8'd1;
                    n_result.log_now = 1'b1;
                end
                n_last_event = i_event_code;
            end
        end else begin
            if (r_countdown != '0) begin
                n_countdown = r_countdown - 16'd1;
            end else begin
                n_countdown = r_refill_period;
                if (r_credit_count < r_credit_max) begin
                    n_credit_count = r_credit_count + 8'd1;
                end
            end
        end
        n_result.credits_left = n_credit_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit_max    <= CREDIT_MAX_RESET;
            r_refill_period <= REFILL_PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CREDIT_MAX:    r_credit_max    <= i_cfg_wdata[7:0];
                CFG_REFILL_PERIOD: r_refill_period <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit_count <= CREDIT_MAX_RESET;
            r_last_event   <= EV_NONE;
            r_countdown    <= REFILL_PERIOD_RESET;
        end else if (w_accept) begin
            r_credit_count <= n_credit_count;
            r_last_event   <= n_last_event;
            r_countdown    <= n_countdown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (w_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (w_accept) begin
                if (r_out_valid && !w_take) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_accept) begin
            if (r_out_valid && !w_take) begin
                r_skid <= n_result;
            end else begin
                r_out <= n_result;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_log_now      = r_out.log_now;
    assign o_credits_left = r_out.credits_left;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_empty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req_type == REQ_EVENT && r_credit_count == '0
        |=> r_credit_count == '0 && $stable(r_last_event))
        else $error("event changed state with no credits");

    a_tick_no_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req_type == REQ_TICK
        |=> r_credit_count >= $past(r_credit_count))
        else $error("tick reduced credits");

    a_log_spends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_result.log_now
        |=> r_credit_count == $past(r_credit_count) - 8'd1)
        else $error("logged event did not spend a credit");

endmodule
